### hw/rtl/rmst_pkg.sv
package rmst_pkg;

  localparam int unsigned SampleW   = 8;
  localparam int unsigned FracBits  = 8;
  localparam int unsigned StateW    = 16;
  localparam int unsigned FactorW   = 8;
  localparam int unsigned AvgW      = 8;
  localparam int unsigned StdW      = 4;
  localparam int unsigned RootW     = 8;
  localparam int unsigned SqrtSteps = 6;
  localparam int unsigned DivSteps  = RootW;
  localparam int unsigned InDataW   = 8;
  localparam int unsigned OutDataW  = 16;

  localparam logic [FactorW-1:0] SmoothReset = 8'd32;
  localparam logic [StdW-1:0]    StdMax      = 4'd15;
  localparam int                 RoundAdd    = 127;

  // Datapath commands
  localparam logic [3:0] CMD_NONE      = 4'd0;
  localparam logic [3:0] CMD_LOAD      = 4'd1;
  localparam logic [3:0] CMD_MEAN_MUL  = 4'd2;
  localparam logic [3:0] CMD_MEAN_ADD  = 4'd3;
  localparam logic [3:0] CMD_DEV_MUL   = 4'd4;
  localparam logic [3:0] CMD_VAR_MUL   = 4'd5;
  localparam logic [3:0] CMD_VAR_ADD   = 4'd6;
  localparam logic [3:0] CMD_ROOT_INIT = 4'd7;
  localparam logic [3:0] CMD_DIV_START = 4'd8;
  localparam logic [3:0] CMD_DIV_STEP  = 4'd9;
  localparam logic [3:0] CMD_ROOT_UPD  = 4'd10;
  localparam logic [3:0] CMD_RESULT    = 4'd11;

  typedef struct packed {
    logic [3:0] op;
  } cmd_t;

  typedef struct packed {
    logic root_small;
    logic root_zero;
    logic root_same;
  } status_t;

endpackage

### hw/rtl/rmst_dpath.sv
module rmst_dpath (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [7:0]                cfg_wdata,
  input  logic [7:0]                sample,
  input  rmst_pkg::cmd_t            cmd,
  output rmst_pkg::status_t         status,
  output logic [7:0]                average,
  output logic [3:0]                std_dev
);
  import rmst_pkg::*;

  logic [FactorW-1:0]       smooth_factor;
  logic [StateW-1:0]        mean_q8;
  logic [StateW-1:0]        variance_q8;
  logic [StateW-1:0]        sample_q8;
  logic signed [34:0]       prod;
  logic [23:0]              sq;
  logic [RootW-1:0]         v;
  logic [RootW-1:0]         r;
  logic [RootW-1:0]         rem;
  logic [RootW-1:0]         quo;

  logic signed [16:0]       delta;
  logic signed [25:0]       delta_var;
  logic signed [25:0]       mul_a;
  logic signed [34:0]       product;
  logic signed [33:0]       square;
  logic signed [34:0]       rounded;
  logic [StateW-1:0]        step;
  logic [RootW:0]           rem_sh;
  logic [RootW+1:0]         trial;
  logic [RootW:0]           root_sum;

  // Deviation of the Q8 sample from the current mean
  assign delta     = $signed({1'b0, sample_q8}) - $signed({1'b0, mean_q8});
  assign delta_var = $signed({2'b0, sq}) - $signed({10'b0, variance_q8});
  assign mul_a     = (cmd.op == CMD_VAR_MUL) ? delta_var : {{9{delta[16]}}, delta};
  assign product   = mul_a * $signed({1'b0, smooth_factor});
  assign square    = delta * delta;
  // Add 127, floor shift by eight, then keep sixteen bits of the step
  assign rounded   = prod + 35'sd127;
  assign step      = rounded[23:8];

  // One restoring division bit per cycle
  assign rem_sh    = {rem, quo[RootW-1]};
  assign trial     = {1'b0, rem_sh} - {2'b0, r};
  assign root_sum  = {1'b0, r} + {1'b0, quo};

  assign status.root_small = (v <= 8'd1);
  assign status.root_zero  = (r == '0);
  assign status.root_same  = (root_sum[RootW:1] == r);

  always_ff @(posedge clk) begin
    if (rst) begin
      smooth_factor <= SmoothReset;
      mean_q8       <= '0;
      variance_q8   <= '0;
    end else begin
      if (cfg_we) begin
        smooth_factor <= cfg_wdata;
      end
      if (cmd.op == CMD_MEAN_ADD) begin
        mean_q8 <= mean_q8 + step;
      end
      if (cmd.op == CMD_VAR_ADD) begin
        variance_q8 <= variance_q8 + step;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      CMD_LOAD:      sample_q8 <= {sample, 8'd0};
      CMD_MEAN_MUL,
      CMD_VAR_MUL:   prod <= product;
      CMD_DEV_MUL:   sq <= square[31:8];
      CMD_ROOT_INIT: begin
        v <= variance_q8[15:8];
        r <= variance_q8[15:8];
      end
      CMD_DIV_START: begin
        rem <= '0;
        quo <= v;
      end
      CMD_DIV_STEP: begin
        if (!trial[RootW+1]) begin
          rem <= trial[RootW-1:0];
        end else begin
          rem <= rem_sh[RootW-1:0];
        end
        quo <= {quo[RootW-2:0], ~trial[RootW+1]};
      end
      CMD_ROOT_UPD:  r <= root_sum[RootW:1];
      CMD_RESULT: begin
        average <= mean_q8[15:8];
        std_dev <= (r > {4'd0, StdMax}) ? StdMax : r[StdW-1:0];
      end
      default: ;
    endcase
  end

endmodule

### hw/rtl/rmst_ctrl.sv
module rmst_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_valid,
  output logic              s_ready,
  output logic              m_valid,
  input  logic              m_ready,
  output rmst_pkg::cmd_t    cmd,
  input  rmst_pkg::status_t status
);
  import rmst_pkg::*;

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_MEAN_MUL = 4'd1;
  localparam logic [3:0] ST_MEAN_ADD = 4'd2;
  localparam logic [3:0] ST_DEV_MUL  = 4'd3;
  localparam logic [3:0] ST_VAR_MUL  = 4'd4;
  localparam logic [3:0] ST_VAR_ADD  = 4'd5;
  localparam logic [3:0] ST_ROOT     = 4'd6;
  localparam logic [3:0] ST_CHK      = 4'd7;
  localparam logic [3:0] ST_DIV      = 4'd8;
  localparam logic [3:0] ST_UPD      = 4'd9;
  localparam logic [3:0] ST_DONE     = 4'd10;

  localparam int unsigned DivCntW  = $clog2(DivSteps);
  localparam int unsigned StepCntW = $clog2(SqrtSteps + 1);

  logic [3:0]          state;
  logic [3:0]          state_next;
  logic [DivCntW-1:0]  div_cnt;
  logic [StepCntW-1:0] steps;
  logic                out_free;

  assign out_free = !m_valid || m_ready;
  assign s_ready  = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd.op     = CMD_NONE;
    case (state)
      ST_IDLE: begin
        if (s_valid) begin
          cmd.op     = CMD_LOAD;
          state_next = ST_MEAN_MUL;
        end
      end
      ST_MEAN_MUL: begin
        cmd.op     = CMD_MEAN_MUL;
        state_next = ST_MEAN_ADD;
      end
      ST_MEAN_ADD: begin
        cmd.op     = CMD_MEAN_ADD;
        state_next = ST_DEV_MUL;
      end
      ST_DEV_MUL: begin
        cmd.op     = CMD_DEV_MUL;
        state_next = ST_VAR_MUL;
      end
      ST_VAR_MUL: begin
        cmd.op     = CMD_VAR_MUL;
        state_next = ST_VAR_ADD;
      end
      ST_VAR_ADD: begin
        cmd.op     = CMD_VAR_ADD;
        state_next = ST_ROOT;
      end
      ST_ROOT: begin
        cmd.op     = CMD_ROOT_INIT;
        state_next = ST_CHK;
      end
      ST_CHK: begin
        if (status.root_small || status.root_zero ||
            (steps == StepCntW'(SqrtSteps))) begin
          state_next = ST_DONE;
        end else begin
          cmd.op     = CMD_DIV_START;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.op = CMD_DIV_STEP;
        if (div_cnt == DivCntW'(DivSteps - 1)) begin
          state_next = ST_UPD;
        end
      end
      ST_UPD: begin
        cmd.op     = CMD_ROOT_UPD;
        state_next = status.root_same ? ST_DONE : ST_CHK;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.op     = CMD_RESULT;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      div_cnt <= '0;
      steps   <= '0;
      m_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_DIV) begin
        div_cnt <= div_cnt + 1'b1;
      end else begin
        div_cnt <= '0;
      end
      if (state == ST_ROOT) begin
        steps <= '0;
      end else if (state == ST_UPD) begin
        steps <= steps + 1'b1;
      end
      if (state == ST_DONE && out_free) begin
        m_valid <= 1'b1;
      end else if (m_ready) begin
        m_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (s_valid && s_ready) |=> (state == ST_MEAN_MUL))
    else $error("accepted request did not start the mean update");

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CHK) |-> (steps <= StepCntW'(SqrtSteps)))
    else $error("Newton step count ran past its limit");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && out_free) |=> (m_valid && state == ST_IDLE))
    else $error("finished result not presented");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == CMD_RESULT) |-> out_free)
    else $error("result register overwritten while still held");
`endif

endmodule

### hw/rtl/running_mean_stddev_tracker.sv
// Running mean and standard deviation tracker. Each request carries one
// unsigned 8-bit sample; the block widens it to Q8, moves a 16-bit
// exponentially smoothed mean towards it by smooth_factor/256 of the
// deviation (rounded, floor shift, wrapping modulo 2^16), then moves a 16-bit
// smoothed variance towards the squared deviation from the new mean in the
// same way. Each sample yields exactly one result: the mean's integer part
// and an integer square root of the variance's upper byte, found by up to six
// Newton steps with early exit. The Newton loop's division runs on a
// restoring divider that produces one quotient bit per cycle. A finished
// result waits until the previous one has left the output register. A new
// sample is taken while the previous result still waits at the output
// register. smooth_factor (reset 32) is written through cfg_we/cfg_wdata;
// the user must write it only while idle; the block itself does not enforce it.
module running_mean_stddev_tracker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [7:0]                     cfg_wdata,      // smooth_factor
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [rmst_pkg::InDataW-1:0]   s_axis_tdata,   // [7:0] sample
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [rmst_pkg::OutDataW-1:0]  m_axis_tdata    // [7:0] average, [11:8] std_dev
);
  import rmst_pkg::*;

  cmd_t             cmd;
  status_t          status;
  logic [AvgW-1:0]  average;
  logic [StdW-1:0]  std_dev;

  // Sequencer: steps the datapath through the update and the root search,
  // and holds the result until the downstream side takes it.
  rmst_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .s_ready (s_axis_tready),
    .m_valid (m_axis_tvalid),
    .m_ready (m_axis_tready),
    .cmd     (cmd),
    .status  (status)
  );

  // Arithmetic: state, multiplier, divider and result register.
  rmst_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .sample    (s_axis_tdata[SampleW-1:0]),
    .cmd       (cmd),
    .status    (status),
    .average   (average),
    .std_dev   (std_dev)
  );

  // Pack the result, padding to whole bytes
  assign m_axis_tdata = {{(OutDataW - AvgW - StdW){1'b0}}, std_dev, average};

endmodule

### bench/tb.sv
module tb;
  import rmst_pkg::*;

  // One expected result: integer part of the mean and the square root of
  // the variance's upper byte.
  typedef struct packed {
    logic [AvgW-1:0] avg;
    logic [StdW-1:0] sd;
  } stat_t;

  // Directed plan: either a smoothing-weight write or one sample request.
  // Where the outcome is obvious it is typed in, otherwise it is predicted.
  typedef struct packed {
    logic                is_weight;
    logic [SampleW-1:0]  value;
    logic                typed;
    stat_t               outcome;
  } plan_row_t;

  localparam int PlanRows = 23;
  localparam int HalfPhases = 8;
  localparam int ItemsPerHalf = 94;
  localparam int TailCycles = 80;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [FactorW-1:0]   cfg_wdata = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InDataW-1:0]   s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutDataW-1:0]  m_axis_tdata;

  // Predictor state, kept in step with every accepted request.
  logic [StateW-1:0]  mean_q = '0;
  logic [StateW-1:0]  spread_q = '0;
  logic [FactorW-1:0] weight = SmoothReset;

  stat_t pending_stats[$];
  int    mismatches = 0;
  int    send_idle = 0;
  int    recv_stall = 0;

  running_mean_stddev_tracker dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

  // old + ((delta * w + 127) >> 8) with a floor shift; step and sum wrap to
  // 16 bits.
  function automatic logic [StateW-1:0] smooth_step(logic [StateW-1:0] old,
                                                    longint delta,
                                                    logic [FactorW-1:0] w);
    longint acc;
    acc = (delta * longint'(w) + RoundAdd) >>> FracBits;
    return old + acc[StateW-1:0];
  endfunction

  // Newton integer root: start from the operand, at most six steps, stop
  // once the guess holds, clamp to the field.
  function automatic logic [StdW-1:0] newton_sqrt(logic [RootW-1:0] v);
    int unsigned r;
    int unsigned prev;
    if (v <= 1) return v[StdW-1:0];
    r = v;
    for (int i = 0; i < SqrtSteps; i++) begin
      prev = r;
      if (r == 0) break;
      r = (r + v / r) >> 1;
      if (r == prev) break;
    end
    return (r > StdMax) ? StdMax : r[StdW-1:0];
  endfunction

  // Advance mean then variance for one sample and form the result.
  function automatic stat_t track_sample(logic [SampleW-1:0] s);
    longint level;
    longint dev;
    longint sq;
    stat_t  r;
    level = longint'({s, 8'h00});
    mean_q = smooth_step(mean_q, level - longint'(mean_q), weight);
    dev = level - longint'(mean_q);
    sq = (dev * dev) >>> FracBits;
    spread_q = smooth_step(spread_q, sq - longint'(spread_q), weight);
    r.avg = mean_q[StateW-1:FracBits];
    r.sd = newton_sqrt(spread_q[StateW-1:FracBits]);
    return r;
  endfunction

  task automatic report(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("tb: %s", msg);
  endtask

  // Offer one sample, hold it until taken, then predict and perhaps idle.
  task automatic send_sample(input logic [SampleW-1:0] s, input logic typed,
                             input stat_t typed_stat);
    stat_t forecast;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= s;
    do @(posedge clk); while (!s_axis_tready);
    forecast = track_sample(s);
    pending_stats.push_back(typed ? typed_stat : forecast);
    if ($urandom_range(0, 99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle);
    end
  endtask

  // Drop valid and wait until every result owed has come back; every request
  // yields a result, so the block is idle afterwards.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk);
  endtask

  task automatic write_weight(input logic [FactorW-1:0] w);
    settle();
    cfg_we <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_we <= 1'b0;
    weight = w;
  endtask

  // Result side: check each accepted result, then roll the stall for the
  // next edge.
  always @(posedge clk) begin
    stat_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_stats.size() == 0) begin
        report($sformatf("unexpected result avg=%0d sd=%0d",
                         m_axis_tdata[7:0], m_axis_tdata[11:8]));
      end else begin
        want = pending_stats.pop_front();
        if (m_axis_tdata[7:0] !== want.avg)
          report($sformatf("average: expected %0d, got %0d", want.avg, m_axis_tdata[7:0]));
        if (m_axis_tdata[11:8] !== want.sd)
          report($sformatf("std_dev: expected %0d, got %0d", want.sd, m_axis_tdata[11:8]));
      end
    end
    m_axis_tready <= ($urandom_range(0, 99) >= recv_stall);
  end

  plan_row_t opening_plan [PlanRows] = '{
    // reset weight, zero state: zero in gives zero out
    '{1'b0, 8'd0,   1'b1, '{8'd0, 4'd0}},
    '{1'b0, 8'd0,   1'b1, '{8'd0, 4'd0}},
    // full weight from rest: mean jumps to 65025, variance stays small
    '{1'b1, 8'd255, 1'b0, '0},
    '{1'b0, 8'd255, 1'b1, '{8'd254, 4'd0}},
    '{1'b0, 8'd0,   1'b1, '{8'd0, 4'd0}},
    // half weight, swinging extremes: variance grows, root runs all steps
    '{1'b1, 8'd128, 1'b0, '0},
    '{1'b0, 8'd255, 1'b0, '0},
    '{1'b0, 8'd0,   1'b0, '0},
    '{1'b0, 8'd255, 1'b0, '0},
    '{1'b0, 8'd0,   1'b0, '0},
    '{1'b0, 8'd255, 1'b0, '0},
    '{1'b0, 8'd0,   1'b0, '0},
    // zero weight freezes the state
    '{1'b1, 8'd0,   1'b0, '0},
    '{1'b0, 8'd255, 1'b0, '0},
    '{1'b0, 8'd0,   1'b0, '0},
    // smallest non-zero weight
    '{1'b1, 8'd1,   1'b0, '0},
    '{1'b0, 8'd255, 1'b0, '0},
    '{1'b0, 8'd0,   1'b0, '0},
    // back to the reset weight, every sample bit both ways
    '{1'b1, 8'd32,  1'b0, '0},
    '{1'b0, 8'd170, 1'b0, '0},
    '{1'b0, 8'd85,  1'b0, '0},
    '{1'b0, 8'd1,   1'b0, '0},
    '{1'b0, 8'd254, 1'b0, '0}
  };

  initial begin
    int                 pick;
    int                 pattern;
    int                 left;
    logic [SampleW-1:0] level;
    logic [SampleW-1:0] s;
    logic [FactorW-1:0] w;
    pattern = 0;
    left = 0;
    level = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < PlanRows; i++) begin
      if (opening_plan[i].is_weight)
        write_weight(opening_plan[i].value);
      else
        send_sample(opening_plan[i].value, opening_plan[i].typed, opening_plan[i].outcome);
    end

    // Random part: two fresh weights per idling phase.
    for (int half = 0; half < HalfPhases; half++) begin
      case (half / 2)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 82; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 82; end
        default: begin send_idle = 23; recv_stall = 23; end
      endcase
      pick = $urandom_range(0, 5);
      case (pick)
        0: w = 8'd0;
        1: w = 8'd255;
        2: w = 8'd1;
        default: w = 8'($urandom_range(0, 255));
      endcase
      write_weight(w);
      for (int n = 0; n < ItemsPerHalf; n++) begin
        // Bursts of one sample shape: uniform, swinging extremes, noisy
        // level or flat level.
        if (left == 0) begin
          pattern = $urandom_range(0, 3);
          left = $urandom_range(8, 24);
          level = 8'($urandom_range(0, 255));
        end
        left--;
        case (pattern)
          0: s = 8'($urandom_range(0, 255));
          1: s = n[0] ? 8'($urandom_range(240, 255)) : 8'($urandom_range(0, 15));
          2: s = level ^ 8'($urandom_range(0, 7));
          default: s = level;
        endcase
        send_sample(s, 1'b0, '0);
      end
    end

    settle();
    repeat (TailCycles) @(posedge clk);
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
